[design/mbrc_pkg.sv]
package mbrc_pkg;

   // request channel payload: one received byte and its end-of-frame mark
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_payload_type;

   typedef enum logic [2:0] {
      VERDICT_ACCEPTED        = 3'd0,
      VERDICT_ILLEGAL_FUNC    = 3'd1,
      VERDICT_ILLEGAL_DATA    = 3'd2,
      VERDICT_BAD_LENGTH      = 3'd3,
      VERDICT_FOREIGN_ADDRESS = 3'd4,
      VERDICT_CRC_ERROR       = 3'd5,
      VERDICT_BROADCAST       = 3'd6
   } verdict_type;

   typedef struct packed {
      verdict_type verdict;
      logic [7:0]  func_code;
      logic [15:0] start_address;
      logic [15:0] quantity_or_value;
      logic [7:0]  write_len;
      logic [8:0]  frame_length;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      CSR_OWN_ADDRESS     = 2'd0,
      CSR_RECEIVER_ENABLE = 2'd1
   } csr_index_type;

   // function codes
   localparam logic [7:0] FC_READ_COILS          = 8'd1;
   localparam logic [7:0] FC_READ_DISCRETE       = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING        = 8'd3;
   localparam logic [7:0] FC_READ_INPUT          = 8'd4;
   localparam logic [7:0] FC_WRITE_SINGLE_COIL   = 8'd5;
   localparam logic [7:0] FC_WRITE_SINGLE_REG    = 8'd6;
   localparam logic [7:0] FC_WRITE_MULTI_COILS   = 8'd15;
   localparam logic [7:0] FC_WRITE_MULTI_REGS    = 8'd16;

   localparam logic [7:0]  BROADCAST_ADDRESS   = 8'd0;
   localparam logic [15:0] CRC_INIT            = 16'hFFFF;
   localparam logic [15:0] CRC_POLY            = 16'hA001;
   localparam logic [15:0] MAX_READ_REGS       = 16'd125;
   localparam logic [15:0] MAX_WRITE_REGS      = 16'd123;
   localparam logic [15:0] MAX_READ_BITS       = 16'd2000;
   localparam logic [15:0] MAX_WRITE_BITS      = 16'd1968;
   localparam logic [15:0] COIL_ON             = 16'hFF00;
   localparam logic [15:0] COIL_OFF            = 16'h0000;
   localparam int          HDR_DEPTH           = 7;
   localparam int          MIN_FRAME_BYTES     = 4;

endpackage

[design/modbus_rtu_request_checker_core.sv]
// Modbus RTU request checker. Feed the received bytes of a request one per
// request on the req_ channel, with frame_end set on the last byte before line
// idle. The block counts the bytes, holds the address, function code and first
// five data bytes, and runs the CRC-16 (reflected 0xA001, start 0xFFFF) over all
// but the final two bytes. On the end byte it issues one response carrying a
// verdict (length, then address, then CRC, then broadcast, then per function
// code checks) and the decoded header fields; absent data bytes read as zero.
// A byte taken after MAX_FRAME_BYTES bytes is dropped and makes the frame a
// length error. Throughput is one byte per clock while req_stall is low: the
// byte is held in an input register, and the CRC step, header capture and
// verdict logic sit between that register and the response register.
// req_stall rises only when the response register is still held by rsp_stall
// and the held byte is an end byte taken while the receiver is enabled. With
// receiver_enable clear, bytes are consumed and ignored. Write the CSRs only
// while the block is idle; csr_ready is always high.
module modbus_rtu_request_checker_core
   import mbrc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  csr_index_type   csr_index,
   input  logic [7:0]      csr_wdata
);

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int LEN_W = 10;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

   // configuration
   logic [7:0] own_address_ff, own_address_in;
   logic       receiver_enable_ff, receiver_enable_in;

   // input register
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff, in_data_in;

   // frame state
   logic [15:0]      crc_ff, crc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             overflow_ff, overflow_in;
   logic [15:0]      last_two_ff, last_two_in;
   logic [7:0]       hdr_ff [HDR_DEPTH];
   logic [7:0]       hdr_in [HDR_DEPTH];

   // response register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic req_accept, out_free, s1_fire, s1_work, result_load;

   // per-byte next values, before the end-of-frame clear
   logic [15:0]      crc_nx, last_nx;
   logic [CNT_W-1:0] cnt_nx, dlen;
   logic             ovf_nx;
   logic [7:0]       hdr_nx [HDR_DEPTH];
   logic [7:0]       data_b [5];
   logic [7:0]       fc, addr;
   logic [15:0]      sa, q, recv;
   logic [LEN_W-1:0] dlen_w, bc_w;
   logic [16:0]      q_w;
   verdict_type      fc_verdict, verdict;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // an end byte while enabled needs the response register; anything else moves
   assign s1_fire    = in_valid_ff &&
                       (!(in_data_ff.frame_end && receiver_enable_ff) || out_free);
   assign s1_work    = s1_fire && receiver_enable_ff;
   assign result_load = s1_work && in_data_ff.frame_end;
   assign req_stall  = in_valid_ff && !s1_fire;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      own_address_in     = own_address_ff;
      receiver_enable_in = receiver_enable_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_OWN_ADDRESS:     own_address_in = csr_wdata;
            CSR_RECEIVER_ENABLE: receiver_enable_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_data_in  = req_payload;
      end else if (s1_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Per-byte update: CRC over the byte two behind, header capture, count
   // ---------------------------------------------------------------------
   always_comb begin
      logic [15:0] c;
      c       = crc_ff ^ {8'h00, last_two_ff[15:8]};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      crc_nx  = crc_ff;
      cnt_nx  = count_ff;
      ovf_nx  = overflow_ff;
      last_nx = last_two_ff;
      hdr_nx  = hdr_ff;
      if (count_ff < CNT_MAX) begin
         if (count_ff >= CNT_W'(2)) begin
            crc_nx = c;
         end
         if (count_ff < CNT_W'(HDR_DEPTH)) begin
            hdr_nx[count_ff[2:0]] = in_data_ff.rx_byte;
         end
         last_nx = {last_two_ff[7:0], in_data_ff.rx_byte};
         cnt_nx  = count_ff + CNT_W'(1);
      end else begin
         // drop the byte and mark the frame oversize
         ovf_nx = 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Header decode; data byte i exists only below count - 4
   // ---------------------------------------------------------------------
   always_comb begin
      dlen = (cnt_nx >= CNT_W'(MIN_FRAME_BYTES)) ? cnt_nx - CNT_W'(MIN_FRAME_BYTES)
                                                 : '0;
      for (int i = 0; i < 5; i++) begin
         data_b[i] = (dlen > CNT_W'(i)) ? hdr_nx[2+i] : 8'h00;
      end
      fc     = (cnt_nx >= CNT_W'(2)) ? hdr_nx[1] : 8'h00;
      addr   = (cnt_nx >= CNT_W'(1)) ? hdr_nx[0] : 8'h00;
      sa     = {data_b[0], data_b[1]};
      q      = {data_b[2], data_b[3]};
      recv   = {last_nx[7:0], last_nx[15:8]};
      dlen_w = LEN_W'(dlen);
      bc_w   = LEN_W'(data_b[4]);
      q_w    = {1'b0, q};
   end

   // per function code checks
   always_comb begin
      fc_verdict = VERDICT_ACCEPTED;
      if (fc inside {FC_READ_HOLDING, FC_READ_INPUT}) begin
         if (dlen_w != LEN_W'(4) || q == 16'd0 || q > MAX_READ_REGS) begin
            fc_verdict = VERDICT_ILLEGAL_DATA;
         end
      end else if (fc inside {FC_READ_COILS, FC_READ_DISCRETE}) begin
         if (dlen_w != LEN_W'(4) || q == 16'd0 || q > MAX_READ_BITS) begin
            fc_verdict = VERDICT_ILLEGAL_DATA;
         end
      end else if (fc == FC_WRITE_SINGLE_REG) begin
         if (dlen_w != LEN_W'(4)) begin
            fc_verdict = VERDICT_ILLEGAL_DATA;
         end
      end else if (fc == FC_WRITE_SINGLE_COIL) begin
         if (dlen_w != LEN_W'(4) || (q != COIL_OFF && q != COIL_ON)) begin
            fc_verdict = VERDICT_ILLEGAL_DATA;
         end
      end else if (fc == FC_WRITE_MULTI_REGS) begin
         if (dlen_w < LEN_W'(5) || q == 16'd0 || q > MAX_WRITE_REGS ||
             {q_w[15:0], 1'b0} != 17'(bc_w) || dlen_w != LEN_W'(5) + bc_w) begin
            fc_verdict = VERDICT_ILLEGAL_DATA;
         end
      end else if (fc == FC_WRITE_MULTI_COILS) begin
         if (dlen_w < LEN_W'(5) || q == 16'd0 || q > MAX_WRITE_BITS ||
             ((q_w + 17'd7) >> 3) != 17'(bc_w) || dlen_w != LEN_W'(5) + bc_w) begin
            fc_verdict = VERDICT_ILLEGAL_DATA;
         end
      end else begin
         fc_verdict = VERDICT_ILLEGAL_FUNC;
      end
   end

   // verdict priority: length, address, CRC, broadcast, function checks
   always_comb begin
      if (ovf_nx || cnt_nx < CNT_W'(MIN_FRAME_BYTES)) begin
         verdict = VERDICT_BAD_LENGTH;
      end else if (addr != BROADCAST_ADDRESS && addr != own_address_ff) begin
         verdict = VERDICT_FOREIGN_ADDRESS;
      end else if (crc_nx != recv) begin
         verdict = VERDICT_CRC_ERROR;
      end else if (addr == BROADCAST_ADDRESS) begin
         verdict = VERDICT_BROADCAST;
      end else begin
         verdict = fc_verdict;
      end
   end

   // ---------------------------------------------------------------------
   // State next values; clear the frame state after an end byte
   // ---------------------------------------------------------------------
   always_comb begin
      crc_in      = crc_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      last_two_in = last_two_ff;
      hdr_in      = hdr_ff;
      if (s1_work) begin
         hdr_in = hdr_nx;
         if (in_data_ff.frame_end) begin
            crc_in      = CRC_INIT;
            count_in    = '0;
            overflow_in = 1'b0;
            last_two_in = '0;
         end else begin
            crc_in      = crc_nx;
            count_in    = cnt_nx;
            overflow_in = ovf_nx;
            last_two_in = last_nx;
         end
      end
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (result_load) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.verdict           = verdict;
         rsp_data_in.func_code         = fc;
         rsp_data_in.start_address     = sa;
         rsp_data_in.quantity_or_value = q;
         rsp_data_in.write_len         = data_b[4];
         rsp_data_in.frame_length      = 9'(cnt_nx);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff     <= 8'd1;
         receiver_enable_ff <= 1'b0;
         in_valid_ff        <= 1'b0;
         crc_ff             <= CRC_INIT;
         count_ff           <= '0;
         overflow_ff        <= 1'b0;
         last_two_ff        <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         own_address_ff     <= own_address_in;
         receiver_enable_ff <= receiver_enable_in;
         in_valid_ff        <= in_valid_in;
         crc_ff             <= crc_in;
         count_ff           <= count_in;
         overflow_ff        <= overflow_in;
         last_two_ff        <= last_two_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      hdr_ff      <= hdr_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   // a fresh response only follows an end byte processed while enabled
   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall)) |-> $past(result_load))
      else $error("response appeared without an end byte");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("byte count beyond frame limit");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (count_ff == CNT_MAX))
      else $error("overflow marked before frame limit reached");

   a_disabled_quiet: assert property (@(posedge clock) disable iff (reset)
      !receiver_enable_ff |-> !result_load)
      else $error("verdict issued while receiver disabled");
`endif

endmodule
